// File: sv/resultant_envelope_tracker_defines.svh
// Assertion macros for the resultant envelope tracker.
// Included by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef RESULTANT_ENVELOPE_TRACKER_DEFINES_SVH
`define RESULTANT_ENVELOPE_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define RET_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ret assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define RET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ret assertion failed");
`else
`define RET_ASSERT(lbl, prop)
`define RET_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: sv/ret_pkg.sv
// Package for the resultant envelope tracker: widths, record types, saturating abs.
// No dependencies; used by the channel interfaces and the top level.
package ret_pkg;

  localparam int unsigned ENTRIES  = 4096;
  localparam int unsigned NumComp  = 3;
  localparam int unsigned CompW    = 32;
  localparam int unsigned MagW     = CompW - 1;
  localparam int unsigned IdxW     = 12;
  localparam int unsigned SqW      = 2 * MagW;
  localparam int unsigned NormW    = SqW + 2;
  localparam int unsigned IdxSpan  = 1 << IdxW;
  localparam int unsigned MemDepth = (ENTRIES < IdxSpan) ? ENTRIES : IdxSpan;
  localparam int unsigned AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  // writes still in flight between the memory read and the write-back
  localparam int unsigned FwdDepth = 3;

  typedef logic [IdxW-1:0]         idx_t;
  typedef logic signed [CompW-1:0] comp_t;
  typedef logic [MagW-1:0]         mag_t;
  typedef mag_t [NumComp-1:0]      vec3_t;
  typedef logic [SqW-1:0]          sq_t;
  typedef sq_t [NumComp-1:0]       sq3_t;
  typedef logic [NormW-1:0]        norm_t;

  typedef struct packed {
    vec3_t frc;
    vec3_t mom;
  } rec_t;

  // |v|, with the most negative value saturating to the largest magnitude
  function automatic mag_t sat_abs(input comp_t v);
    comp_t neg;
    neg = -v;
    if (v == {1'b1, {(CompW-1){1'b0}}}) begin
      return {MagW{1'b1}};
    end else if (v[CompW-1]) begin
      return neg[MagW-1:0];
    end else begin
      return v[MagW-1:0];
    end
  endfunction

  function automatic sq_t square(input mag_t a);
    return SqW'(a) * SqW'(a);
  endfunction

endpackage

// File: sv/ret_if.sv
// Valid/ready channel interfaces for the resultant envelope tracker.
// Depends on ret_pkg for field widths.
interface ret_in_if;
  import ret_pkg::*;

  logic  valid;
  logic  ready;
  idx_t  entry_index;
  logic  first_step;
  comp_t force_x;
  comp_t force_y;
  comp_t force_z;
  comp_t moment_x;
  comp_t moment_y;
  comp_t moment_z;

  modport source (
    output valid, entry_index, first_step,
    output force_x, force_y, force_z, moment_x, moment_y, moment_z,
    input  ready
  );

  modport sink (
    input  valid, entry_index, first_step,
    input  force_x, force_y, force_z, moment_x, moment_y, moment_z,
    output ready
  );
endinterface

interface ret_out_if;
  import ret_pkg::*;

  logic valid;
  logic ready;
  idx_t out_index;
  mag_t env_force_x;
  mag_t env_force_y;
  mag_t env_force_z;
  mag_t env_moment_x;
  mag_t env_moment_y;
  mag_t env_moment_z;
  logic moment_replaced;

  modport source (
    output valid, out_index, env_force_x, env_force_y, env_force_z,
    output env_moment_x, env_moment_y, env_moment_z, moment_replaced,
    input  ready
  );

  modport sink (
    input  valid, out_index, env_force_x, env_force_y, env_force_z,
    input  env_moment_x, env_moment_y, env_moment_z, moment_replaced,
    output ready
  );
endinterface

// File: sv/resultant_envelope_tracker.sv
// Resultant envelope tracker, top level. Depends on ret_pkg, ret_if.sv and
// resultant_envelope_tracker_defines.svh.
//
// Usage: items arrive on in_ch (valid/ready); a transfer carries an entry
// index, a first-step flag, three forces and three moments. Every input
// transfer yields exactly one out_ch transfer with the updated record of that
// entry: running max |force| per component, and the |moments| of the step
// with the largest squared moment norm so far.
// An input transfer passes stage registers 1 to 4 before out_ch.valid. Throughput:
// one item per cycle while out_ch takes results, set by the compare/select loop at
// write-back and the one-read/one-write record memory; back-to-back hits on one
// entry are forwarded from a three-deep write history.
// Stall: the four stages advance together; in_ch.ready is high while the
// output register is empty or being taken, so a waiting result holds the
// whole pipeline without loss or repetition.
// Reset clears only the stage valid bits and history valid bits. The record
// memory is not cleared: every entry must see its first-step item before any
// other item for that entry.
`include "resultant_envelope_tracker_defines.svh"

module resultant_envelope_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  ret_in_if.sink     in_ch,
  ret_out_if.source  out_ch
);
  import ret_pkg::*;

  typedef struct packed {
    idx_t  idx;
    rec_t  rec;
    norm_t norm;
  } hist_t;

  logic en;
  logic in_rng;
  vec3_t fa_in, ma_in;

  // stage 1: input and raw memory read
  logic  v1_q;
  idx_t  idx1_q;
  logic  first1_q, rng1_q;
  vec3_t fa1_q, ma1_q;
  rec_t  rd1_q;

  // stage 2: squares
  logic  v2_q;
  idx_t  idx2_q;
  logic  first2_q, rng2_q;
  vec3_t fa2_q, ma2_q;
  rec_t  old2_q;
  sq3_t  mq2_q, oq2_q;

  // stage 3: norms
  logic  v3_q;
  idx_t  idx3_q;
  logic  first3_q, rng3_q;
  vec3_t fa3_q, ma3_q;
  rec_t  old3_q;
  norm_t newn3_q, oldn3_q;

  // stage 4: output register and write history
  logic  v4_q;
  idx_t  idx4_q;
  rec_t  rec4_q;
  logic  repl4_q;
  logic  [FwdDepth-1:0] hv_q;
  hist_t hist_q [FwdDepth];

  rec_t  mem [MemDepth];

  rec_t  old_rec, new_rec;
  norm_t old_norm, new_norm;
  logic  replace;
  logic  wr_en;

  assign en          = !v4_q || out_ch.ready;
  assign in_ch.ready = en;
  assign in_rng      = 32'(in_ch.entry_index) < ENTRIES;

  always_comb begin
    fa_in[0] = sat_abs(in_ch.force_x);
    fa_in[1] = sat_abs(in_ch.force_y);
    fa_in[2] = sat_abs(in_ch.force_z);
    ma_in[0] = sat_abs(in_ch.moment_x);
    ma_in[1] = sat_abs(in_ch.moment_y);
    ma_in[2] = sat_abs(in_ch.moment_z);
  end

  // Pick the newest in-flight write to this entry over the memory data.
  always_comb begin
    old_rec  = old3_q;
    old_norm = oldn3_q;
    for (int i = FwdDepth - 1; i >= 0; i--) begin
      if (hv_q[i] && hist_q[i].idx == idx3_q) begin
        old_rec  = hist_q[i].rec;
        old_norm = hist_q[i].norm;
      end
    end
    replace = first3_q || (old_norm < newn3_q);
    for (int k = 0; k < NumComp; k++) begin
      if (first3_q || fa3_q[k] > old_rec.frc[k]) begin
        new_rec.frc[k] = fa3_q[k];
      end else begin
        new_rec.frc[k] = old_rec.frc[k];
      end
    end
    new_rec.mom = replace ? ma3_q : old_rec.mom;
    new_norm    = replace ? newn3_q : old_norm;
  end

  assign wr_en = en && v3_q && rng3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd1_q <= mem[in_ch.entry_index[AddrW-1:0]];
    end
    if (wr_en) begin
      mem[idx3_q[AddrW-1:0]] <= new_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      hv_q <= '0;
    end else if (en) begin
      v1_q <= in_ch.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      hv_q <= {hv_q[FwdDepth-2:0], v3_q && rng3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx1_q   <= in_ch.entry_index;
      first1_q <= in_ch.first_step || !in_rng;
      rng1_q   <= in_rng;
      fa1_q    <= fa_in;
      ma1_q    <= ma_in;

      idx2_q   <= idx1_q;
      first2_q <= first1_q;
      rng2_q   <= rng1_q;
      fa2_q    <= fa1_q;
      ma2_q    <= ma1_q;
      old2_q   <= rd1_q;
      for (int k = 0; k < NumComp; k++) begin
        mq2_q[k] <= square(ma1_q[k]);
        oq2_q[k] <= square(rd1_q.mom[k]);
      end

      idx3_q   <= idx2_q;
      first3_q <= first2_q;
      rng3_q   <= rng2_q;
      fa3_q    <= fa2_q;
      ma3_q    <= ma2_q;
      old3_q   <= old2_q;
      newn3_q  <= NormW'(mq2_q[0]) + NormW'(mq2_q[1]) + NormW'(mq2_q[2]);
      oldn3_q  <= NormW'(oq2_q[0]) + NormW'(oq2_q[1]) + NormW'(oq2_q[2]);

      idx4_q   <= idx3_q;
      rec4_q   <= new_rec;
      repl4_q  <= replace;
      hist_q[0] <= '{idx: idx3_q, rec: new_rec, norm: new_norm};
      for (int i = 1; i < FwdDepth; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  assign out_ch.valid           = v4_q;
  assign out_ch.out_index       = idx4_q;
  assign out_ch.env_force_x     = rec4_q.frc[0];
  assign out_ch.env_force_y     = rec4_q.frc[1];
  assign out_ch.env_force_z     = rec4_q.frc[2];
  assign out_ch.env_moment_x    = rec4_q.mom[0];
  assign out_ch.env_moment_y    = rec4_q.mom[1];
  assign out_ch.env_moment_z    = rec4_q.mom[2];
  assign out_ch.moment_replaced = repl4_q;

  // newest history entry mirrors the output register
  `RET_ASSERT(a_hist_mirrors_out, hv_q[0] |-> (v4_q && hist_q[0].idx == out_ch.out_index && hist_q[0].rec.mom[0] == out_ch.env_moment_x))
  // a forwarded hit can only grow the force envelope
  `RET_ASSERT_NEXT(a_frc_fwd_grows, en && v3_q && !first3_q && hv_q[0] && hist_q[0].idx == idx3_q, out_ch.env_force_x >= $past(hist_q[0].rec.frc[0]))
  // a forwarded hit can only grow the stored moment norm
  `RET_ASSERT_NEXT(a_norm_fwd_grows, en && v3_q && !first3_q && hv_q[0] && hist_q[0].idx == idx3_q, hist_q[0].norm >= $past(hist_q[0].norm))
  // a stalled result freezes the pipeline behind it
  `RET_ASSERT_NEXT(a_stall_freezes, out_ch.valid && !out_ch.ready, $stable(hv_q) && $stable(v3_q) && $stable(idx3_q))

endmodule
